// File: hw/rtl/rtt_pkg.sv
// Shared constants, codes and control structs for the request tracker.
`timescale 1ns / 1ps
package rtt_pkg;

	localparam int TBL_ENTRIES = 32;
	localparam int TBL_IDX_W   = $clog2(TBL_ENTRIES);
	localparam int ID_W        = 5;
	localparam int CNT_W       = $clog2(TBL_ENTRIES + 1);
	localparam int MODE_W      = 3;
	localparam int KIND_W      = 4;
	localparam int HDR_W       = 8;
	localparam int LEN_W       = 12;
	localparam int EP_W        = 8;
	localparam int TMO_W       = 16;
	localparam int STEP_W      = 16;
	localparam int TIME_W      = 32;

	localparam logic [STEP_W-1:0] STEP_RESET   = STEP_W'(100);
	localparam logic [LEN_W-1:0]  MIN_RESP_LEN = LEN_W'(2);

	localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SEND  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FAIL  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RESP  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TICK  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLOSE = 3'd5;

	localparam logic [KIND_W-1:0] KIND_ALLOC   = 4'd0;
	localparam logic [KIND_W-1:0] KIND_REG     = 4'd1;
	localparam logic [KIND_W-1:0] KIND_COLL    = 4'd2;
	localparam logic [KIND_W-1:0] KIND_EMPTY   = 4'd3;
	localparam logic [KIND_W-1:0] KIND_DELIV   = 4'd4;
	localparam logic [KIND_W-1:0] KIND_ORPHAN  = 4'd5;
	localparam logic [KIND_W-1:0] KIND_SHORT   = 4'd6;
	localparam logic [KIND_W-1:0] KIND_EXPIRED = 4'd7;
	localparam logic [KIND_W-1:0] KIND_FAILRM  = 4'd8;
	localparam logic [KIND_W-1:0] KIND_CLOSED  = 4'd9;

	typedef struct packed {
		logic accept;
		logic exec;
		logic sweep;
		logic check;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
	} sts_t;

endpackage

// File: hw/rtl/request_tracker_with_timeouts_core.sv
// Top level of the outstanding-request tracker with timeouts.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------------------
//  request   | start, busy               | mode, header_byte, message_length,
//            |                           | target_endpoint, reply_window
//  result    | result_valid (strobe)     | kind, result_id, entry_endpoint,
//            |                           | pending_count, last
//  config    | cfg_wr_en                 | cfg_wr_data (tick step in ms)
//
// Allocate, send, send-failed and response requests pass through accept, table read and
// update; the result, if any, appears the cycle after the update.
// Tick and close walk the table with one read and one check per entry, then a flush.
// Each result is held back until the next removal is found, so the final one carries last.
// Reset clears every valid bit at once; no clearing pass. Results cannot be stalled.
`timescale 1ns / 1ps
module request_tracker_with_timeouts_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [rtt_pkg::MODE_W-1:0]   mode,
	input  logic [rtt_pkg::HDR_W-1:0]    header_byte,
	input  logic [rtt_pkg::LEN_W-1:0]    message_length,
	input  logic [rtt_pkg::EP_W-1:0]     target_endpoint,
	input  logic [rtt_pkg::TMO_W-1:0]    reply_window,
	input  logic                         cfg_wr_en,
	input  logic [rtt_pkg::STEP_W-1:0]   cfg_wr_data,
	output logic                         result_valid,
	output logic [rtt_pkg::KIND_W-1:0]   kind,
	output logic [rtt_pkg::ID_W-1:0]     result_id,
	output logic [rtt_pkg::EP_W-1:0]     entry_endpoint,
	output logic [rtt_pkg::CNT_W-1:0]    pending_count,
	output logic                         last
);

	rtt_pkg::cmd_t cmd;
	rtt_pkg::sts_t sts;

	rtt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	rtt_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.mode            (mode),
		.header_byte     (header_byte),
		.message_length  (message_length),
		.target_endpoint (target_endpoint),
		.reply_window    (reply_window),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.result_valid    (result_valid),
		.kind            (kind),
		.result_id       (result_id),
		.entry_endpoint  (entry_endpoint),
		.pending_count   (pending_count),
		.last            (last)
	);

endmodule

// File: hw/rtl/rtt_ctrl.sv
// Controller state machine: sequences lookups, updates and table sweeps.
`timescale 1ns / 1ps
module rtt_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rtt_pkg::MODE_W-1:0] mode,
	input  rtt_pkg::sts_t              sts,
	output rtt_pkg::cmd_t              cmd,
	output logic                       busy
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_READ  = 6'b000010,
		S_EXEC  = 6'b000100,
		S_SW_RD = 6'b001000,
		S_SW_CK = 6'b010000,
		S_FLUSH = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.accept = start && (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (mode == rtt_pkg::MODE_TICK || mode == rtt_pkg::MODE_CLOSE) begin
						state_d = S_SW_RD;
					end else if (mode == rtt_pkg::MODE_ALLOC || mode == rtt_pkg::MODE_SEND ||
					             mode == rtt_pkg::MODE_FAIL || mode == rtt_pkg::MODE_RESP) begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_IDLE;
			end
			S_SW_RD: begin
				cmd.sweep = 1'b1;
				state_d   = S_SW_CK;
			end
			S_SW_CK: begin
				cmd.check = 1'b1;
				state_d   = sts.idx_last ? S_FLUSH : S_SW_RD;
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: hw/rtl/rtt_dp.sv
// Datapath: request table, time counter, id counter and result registers.
`timescale 1ns / 1ps
module rtt_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rtt_pkg::cmd_t                cmd,
	output rtt_pkg::sts_t                sts,
	input  logic [rtt_pkg::MODE_W-1:0]   mode,
	input  logic [rtt_pkg::HDR_W-1:0]    header_byte,
	input  logic [rtt_pkg::LEN_W-1:0]    message_length,
	input  logic [rtt_pkg::EP_W-1:0]     target_endpoint,
	input  logic [rtt_pkg::TMO_W-1:0]    reply_window,
	input  logic                         cfg_wr_en,
	input  logic [rtt_pkg::STEP_W-1:0]   cfg_wr_data,
	output logic                         result_valid,
	output logic [rtt_pkg::KIND_W-1:0]   kind,
	output logic [rtt_pkg::ID_W-1:0]     result_id,
	output logic [rtt_pkg::EP_W-1:0]     entry_endpoint,
	output logic [rtt_pkg::CNT_W-1:0]    pending_count,
	output logic                         last
);

	logic [rtt_pkg::MODE_W-1:0]      mode_q;
	logic [rtt_pkg::ID_W-1:0]        id_q;
	logic [rtt_pkg::LEN_W-1:0]       len_q;
	logic [rtt_pkg::EP_W-1:0]        ep_q;
	logic [rtt_pkg::TMO_W-1:0]       tmo_q;

	logic [rtt_pkg::STEP_W-1:0]      step_q;
	logic [rtt_pkg::TIME_W-1:0]      time_q;
	logic [rtt_pkg::ID_W-1:0]        next_id_q;
	logic [rtt_pkg::CNT_W-1:0]       count_q;
	logic [rtt_pkg::TBL_ENTRIES-1:0] valid_q;
	logic [rtt_pkg::TBL_IDX_W-1:0]   idx_q;

	logic [rtt_pkg::EP_W-1:0]        ep_mem_q [rtt_pkg::TBL_ENTRIES];
	logic [rtt_pkg::TIME_W-1:0]      dl_mem_q [rtt_pkg::TBL_ENTRIES];
	logic [rtt_pkg::EP_W-1:0]        rd_ep_q;
	logic [rtt_pkg::TIME_W-1:0]      rd_dl_q;

	logic                            held_vld_q;
	logic [rtt_pkg::KIND_W-1:0]      held_kind_q;
	logic [rtt_pkg::ID_W-1:0]        held_id_q;
	logic [rtt_pkg::EP_W-1:0]        held_ep_q;
	logic [rtt_pkg::CNT_W-1:0]       held_pend_q;

	logic                            res_vld_q;
	logic [rtt_pkg::KIND_W-1:0]      res_kind_q;
	logic [rtt_pkg::ID_W-1:0]        res_id_q;
	logic [rtt_pkg::EP_W-1:0]        res_ep_q;
	logic [rtt_pkg::CNT_W-1:0]       res_pend_q;
	logic                            res_last_q;

	logic [rtt_pkg::TBL_IDX_W-1:0]   slot;
	logic [rtt_pkg::TBL_IDX_W-1:0]   rd_addr;
	logic [rtt_pkg::TIME_W-1:0]      age;
	logic                            expired;
	logic                            sweep_hit;
	logic                            slot_vld;
	logic                            mem_wr;

	assign slot      = rtt_pkg::TBL_IDX_W'(id_q);
	assign rd_addr   = cmd.sweep ? idx_q : slot;
	assign slot_vld  = valid_q[slot];
	assign age       = time_q - rd_dl_q;
	assign expired   = (age != '0) && !age[rtt_pkg::TIME_W-1];
	assign sweep_hit = valid_q[idx_q] && ((mode_q == rtt_pkg::MODE_CLOSE) || expired);
	assign mem_wr    = cmd.exec && (mode_q == rtt_pkg::MODE_SEND) && (len_q != '0);

	assign sts.idx_last = (idx_q == rtt_pkg::TBL_IDX_W'(rtt_pkg::TBL_ENTRIES - 1));

	// capture the request
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= mode;
			id_q   <= header_byte[6:2];
			len_q  <= message_length;
			ep_q   <= target_endpoint;
			tmo_q  <= reply_window;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			ep_mem_q[slot] <= ep_q;
			dl_mem_q[slot] <= time_q + rtt_pkg::TIME_W'(tmo_q);
		end
		rd_ep_q <= ep_mem_q[rd_addr];
		rd_dl_q <= dl_mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.check && sweep_hit) begin
			held_kind_q <= (mode_q == rtt_pkg::MODE_CLOSE) ? rtt_pkg::KIND_CLOSED
			                                               : rtt_pkg::KIND_EXPIRED;
			held_id_q   <= rtt_pkg::ID_W'(idx_q);
			held_ep_q   <= rd_ep_q;
			held_pend_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= rtt_pkg::STEP_RESET;
			time_q     <= '0;
			next_id_q  <= '0;
			count_q    <= '0;
			valid_q    <= '0;
			idx_q      <= '0;
			held_vld_q <= 1'b0;
			res_vld_q  <= 1'b0;
			res_kind_q <= '0;
			res_id_q   <= '0;
			res_ep_q   <= '0;
			res_pend_q <= '0;
			res_last_q <= 1'b0;
		end else begin
			res_vld_q <= 1'b0;
			if (cfg_wr_en) begin
				step_q <= cfg_wr_data;
			end
			if (cmd.accept) begin
				idx_q <= '0;
				if (mode == rtt_pkg::MODE_TICK) begin
					time_q <= time_q + rtt_pkg::TIME_W'(step_q);
				end
			end
			if (cmd.exec) begin
				res_last_q <= 1'b1;
				res_pend_q <= count_q;
				res_id_q   <= id_q;
				res_ep_q   <= '0;
				case (mode_q)
					rtt_pkg::MODE_ALLOC: begin
						res_vld_q  <= 1'b1;
						res_kind_q <= rtt_pkg::KIND_ALLOC;
						res_id_q   <= next_id_q;
						next_id_q  <= next_id_q + 1'b1;
					end
					rtt_pkg::MODE_SEND: begin
						res_vld_q <= 1'b1;
						if (len_q == '0) begin
							res_kind_q <= rtt_pkg::KIND_EMPTY;
							res_id_q   <= '0;
						end else begin
							valid_q[slot] <= 1'b1;
							res_ep_q      <= ep_q;
							if (slot_vld) begin
								res_kind_q <= rtt_pkg::KIND_COLL;
							end else begin
								res_kind_q <= rtt_pkg::KIND_REG;
								count_q    <= count_q + 1'b1;
								res_pend_q <= count_q + 1'b1;
							end
						end
					end
					rtt_pkg::MODE_FAIL: begin
						if (slot_vld) begin
							res_vld_q     <= 1'b1;
							res_kind_q    <= rtt_pkg::KIND_FAILRM;
							res_ep_q      <= rd_ep_q;
							valid_q[slot] <= 1'b0;
							count_q       <= count_q - 1'b1;
							res_pend_q    <= count_q - 1'b1;
						end
					end
					rtt_pkg::MODE_RESP: begin
						res_vld_q <= 1'b1;
						if (len_q < rtt_pkg::MIN_RESP_LEN) begin
							res_kind_q <= rtt_pkg::KIND_SHORT;
							res_id_q   <= '0;
						end else if (slot_vld) begin
							res_kind_q    <= rtt_pkg::KIND_DELIV;
							res_ep_q      <= rd_ep_q;
							valid_q[slot] <= 1'b0;
							count_q       <= count_q - 1'b1;
							res_pend_q    <= count_q - 1'b1;
						end else begin
							res_kind_q <= rtt_pkg::KIND_ORPHAN;
						end
					end
					default: begin
						res_vld_q <= 1'b0;
					end
				endcase
			end
			if (cmd.check) begin
				idx_q <= idx_q + 1'b1;
				if (sweep_hit) begin
					valid_q[idx_q] <= 1'b0;
					count_q        <= count_q - 1'b1;
					held_vld_q     <= 1'b1;
					// release the previous removal; more follow
					if (held_vld_q) begin
						res_vld_q  <= 1'b1;
						res_kind_q <= held_kind_q;
						res_id_q   <= held_id_q;
						res_ep_q   <= held_ep_q;
						res_pend_q <= held_pend_q;
						res_last_q <= 1'b0;
					end
				end
			end
			if (cmd.flush) begin
				held_vld_q <= 1'b0;
				if (held_vld_q) begin
					res_vld_q  <= 1'b1;
					res_kind_q <= held_kind_q;
					res_id_q   <= held_id_q;
					res_ep_q   <= held_ep_q;
					res_pend_q <= held_pend_q;
					res_last_q <= 1'b1;
				end
			end
		end
	end

	assign result_valid   = res_vld_q;
	assign kind           = res_kind_q;
	assign result_id      = res_id_q;
	assign entry_endpoint = res_ep_q;
	assign pending_count  = res_pend_q;
	assign last           = res_last_q;

endmodule

// File: tb/tb_request_tracker_with_timeouts_core.sv
// Self-checking testbench for the outstanding-request tracker: predictor scoreboard and drivers.
`timescale 1ns / 1ps

import rtt_pkg::*;

localparam int SWEEP_MAX_RESULTS = 32;

typedef struct packed {
	logic [KIND_W-1:0] kind;
	logic [ID_W-1:0]   id;
	logic [EP_W-1:0]   ep;
	logic [CNT_W-1:0]  pend;
	logic              last;
} tracker_result_t;

class request_scoreboard;
	bit                 entry_live [TBL_ENTRIES];
	logic [EP_W-1:0]    entry_ep   [TBL_ENTRIES];
	logic [TIME_W-1:0]  entry_due  [TBL_ENTRIES];
	logic [TIME_W-1:0]  now_ms;
	logic [ID_W-1:0]    id_counter;
	logic [CNT_W-1:0]   live_count;
	logic [STEP_W-1:0]  step_ms;
	tracker_result_t    due_results [$];
	int                 mismatches;

	function new();
		foreach (entry_live[i]) begin
			entry_live[i] = 1'b0;
			entry_ep[i]   = '0;
			entry_due[i]  = '0;
		end
		now_ms     = '0;
		id_counter = '0;
		live_count = '0;
		step_ms    = STEP_RESET;
		mismatches = 0;
	endfunction

	function void take_request(logic [MODE_W-1:0] op, logic [HDR_W-1:0] hdr,
			logic [LEN_W-1:0] len, logic [EP_W-1:0] ep, logic [TMO_W-1:0] tmo);
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] lag;
		tracker_result_t   batch [SWEEP_MAX_RESULTS];
		int                slot;
		int                n;
		bit                hit;
		id   = hdr[6:2];
		slot = int'(id) % TBL_ENTRIES;
		n    = 0;
		case (op)
			MODE_ALLOC: begin
				batch[0] = '{KIND_ALLOC, id_counter, '0, live_count, 1'b1};
				n = 1;
				id_counter = id_counter + 1'b1;
			end
			MODE_SEND: begin
				if (len == '0) begin
					batch[0] = '{KIND_EMPTY, '0, '0, live_count, 1'b1};
				end else begin
					hit = entry_live[slot];
					if (!hit)
						live_count = live_count + 1'b1;
					entry_live[slot] = 1'b1;
					entry_ep[slot]   = ep;
					entry_due[slot]  = now_ms + TIME_W'(tmo);
					batch[0] = '{hit ? KIND_COLL : KIND_REG, id, ep, live_count, 1'b1};
				end
				n = 1;
			end
			MODE_FAIL: begin
				if (entry_live[slot]) begin
					entry_live[slot] = 1'b0;
					live_count = live_count - 1'b1;
					batch[0] = '{KIND_FAILRM, id, entry_ep[slot], live_count, 1'b1};
					n = 1;
				end
			end
			MODE_RESP: begin
				if (len < MIN_RESP_LEN) begin
					batch[0] = '{KIND_SHORT, '0, '0, live_count, 1'b1};
				end else if (entry_live[slot]) begin
					entry_live[slot] = 1'b0;
					live_count = live_count - 1'b1;
					batch[0] = '{KIND_DELIV, id, entry_ep[slot], live_count, 1'b1};
				end else begin
					batch[0] = '{KIND_ORPHAN, id, '0, live_count, 1'b1};
				end
				n = 1;
			end
			MODE_TICK: begin
				now_ms = now_ms + TIME_W'(step_ms);
				for (int i = 0; i < TBL_ENTRIES && n < SWEEP_MAX_RESULTS; i++) begin
					lag = now_ms - entry_due[i];
					if (entry_live[i] && lag != '0 && !lag[TIME_W-1]) begin
						entry_live[i] = 1'b0;
						live_count = live_count - 1'b1;
						batch[n] = '{KIND_EXPIRED, ID_W'(i), entry_ep[i], live_count, 1'b0};
						n++;
					end
				end
				if (n > 0)
					batch[n-1].last = 1'b1;
			end
			MODE_CLOSE: begin
				for (int i = 0; i < TBL_ENTRIES; i++) begin
					if (entry_live[i]) begin
						entry_live[i] = 1'b0;
						live_count = live_count - 1'b1;
						if (n < SWEEP_MAX_RESULTS) begin
							batch[n] = '{KIND_CLOSED, ID_W'(i), entry_ep[i], live_count, 1'b0};
							n++;
						end
					end
				end
				live_count = '0;
				if (n > 0) begin
					batch[n-1].pend = '0;
					batch[n-1].last = 1'b1;
				end
			end
			default: begin
			end
		endcase
		for (int k = 0; k < n; k++)
			due_results.push_back(batch[k]);
	endfunction

	function void check_result(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
			logic [EP_W-1:0] ep, logic [CNT_W-1:0] pend, logic last);
		tracker_result_t got;
		tracker_result_t want;
		got = '{kind, id, ep, pend, last};
		if (due_results.size() == 0) begin
			if (mismatches < 10)
				$display("unexpected result: kind %0d id %0d ep %0d pend %0d last %0d",
					got.kind, got.id, got.ep, got.pend, got.last);
			mismatches++;
			return;
		end
		want = due_results.pop_front();
		if (got.kind !== want.kind || got.id !== want.id || got.ep !== want.ep ||
				got.pend !== want.pend || got.last !== want.last) begin
			if (mismatches < 10)
				$display("mismatch: expected kind %0d id %0d ep %0d pend %0d last %0d,",
					want.kind, want.id, want.ep, want.pend, want.last,
					" got kind %0d id %0d ep %0d pend %0d last %0d",
					got.kind, got.id, got.ep, got.pend, got.last);
			mismatches++;
		end
	endfunction
endclass

module tb_request_tracker_with_timeouts_core;
	localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;
	localparam int SWEEP_CYCLES     = 2 * TBL_ENTRIES + 10;
	localparam int RANDOM_PER_PHASE = 36;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [MODE_W-1:0]  mode = '0;
	logic [HDR_W-1:0]   header_byte = '0;
	logic [LEN_W-1:0]   message_length = '0;
	logic [EP_W-1:0]    target_endpoint = '0;
	logic [TMO_W-1:0]   reply_window = '0;
	logic               cfg_wr_en = 1'b0;
	logic [STEP_W-1:0]  cfg_wr_data = '0;
	logic               result_valid;
	logic [KIND_W-1:0]  kind;
	logic [ID_W-1:0]    result_id;
	logic [EP_W-1:0]    entry_endpoint;
	logic [CNT_W-1:0]   pending_count;
	logic               last;

	request_scoreboard tracker = new();
	bit                sender_idles = 1'b0;
	bit                idle_stretch = 1'b1;
	int                issued_allocs = 0;
	int                recent_ids [$];

	request_tracker_with_timeouts_core i_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid === 1'b1)
				tracker.check_result(kind, result_id, entry_endpoint, pending_count, last);
			if (start && !busy)
				tracker.take_request(mode, header_byte, message_length, target_endpoint,
					reply_window);
		end
	end

	initial begin
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

	task automatic issue(input logic [MODE_W-1:0] op, input logic [HDR_W-1:0] hdr,
			input logic [LEN_W-1:0] len, input logic [EP_W-1:0] ep,
			input logic [TMO_W-1:0] tmo);
		start           <= 1'b1;
		mode            <= op;
		header_byte     <= hdr;
		message_length  <= len;
		target_endpoint <= ep;
		reply_window    <= tmo;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (op == MODE_ALLOC)
			issued_allocs++;
		if (sender_idles) begin
			if ($urandom_range(0, 15) == 0)
				idle_stretch = !idle_stretch;
			if (idle_stretch && $urandom_range(0, 2) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 7))
					@(posedge clk);
			end
		end
	endtask

	// hold off until every outstanding request has reported and the sweep has settled
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.due_results.size() != 0 || busy)
			@(posedge clk);
		repeat (SWEEP_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_tick_step(input logic [STEP_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		tracker.step_ms = value;
	endtask

	function automatic logic [HDR_W-1:0] header_for(input logic [ID_W-1:0] id);
		return {1'($urandom), id, 2'($urandom)};
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		if (recent_ids.size() > 0 && $urandom_range(0, 3) != 0)
			return ID_W'(recent_ids[$urandom_range(0, recent_ids.size() - 1)]);
		return ID_W'($urandom);
	endfunction

	function automatic logic [TMO_W-1:0] pick_timeout(input int step);
		int span;
		span = (4 * step > 65535) ? 65535 : 4 * step;
		if (step == 0 || $urandom_range(0, 4) == 0)
			return TMO_W'($urandom);
		return TMO_W'($urandom_range(0, span));
	endfunction

	function automatic logic [LEN_W-1:0] pick_send_length();
		if ($urandom_range(0, 15) == 0)
			return '0;
		return LEN_W'($urandom_range(1, 4095));
	endfunction

	task automatic send_to(input logic [ID_W-1:0] id, input int step);
		issue(MODE_SEND, header_for(id), pick_send_length(), EP_W'($urandom),
			pick_timeout(step));
		recent_ids.push_back(int'(id));
		if (recent_ids.size() > 8)
			void'(recent_ids.pop_front());
	endtask

	task automatic random_request(input int step);
		int pick;
		logic [LEN_W-1:0] len;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			issue(MODE_ALLOC, HDR_W'($urandom), LEN_W'($urandom), EP_W'($urandom),
				TMO_W'($urandom));
			send_to(ID_W'(issued_allocs - 1), step);
		end else if (pick < 40) begin
			send_to(pick_id(), step);
		end else if (pick < 50) begin
			issue(MODE_FAIL, header_for(pick_id()), LEN_W'($urandom), EP_W'($urandom),
				TMO_W'($urandom));
		end else if (pick < 70) begin
			len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 1))
				: LEN_W'($urandom_range(2, 4095));
			issue(MODE_RESP, header_for(pick_id()), len, EP_W'($urandom), TMO_W'($urandom));
		end else if (pick < 93) begin
			issue(MODE_TICK, HDR_W'($urandom), LEN_W'($urandom), EP_W'($urandom),
				TMO_W'($urandom));
		end else if (pick < 97) begin
			issue(MODE_CLOSE, HDR_W'($urandom), LEN_W'($urandom), EP_W'($urandom),
				TMO_W'($urandom));
		end else begin
			issue($urandom_range(0, 1) ? MODE_RSVD_HI : MODE_RSVD_LO, HDR_W'($urandom),
				LEN_W'($urandom), EP_W'($urandom), TMO_W'($urandom));
		end
	endtask

	// occupy every entry, then sweep them all out in one go
	task automatic fill_table(input int step, input bit sweep_by_tick);
		int base;
		base = $urandom_range(0, TBL_ENTRIES - 1);
		for (int k = 0; k < TBL_ENTRIES; k++)
			issue(MODE_SEND, header_for(ID_W'(base + k)), LEN_W'($urandom_range(1, 4095)),
				EP_W'($urandom),
				sweep_by_tick ? TMO_W'($urandom_range(0, step - 1)) : TMO_W'($urandom));
		issue(sweep_by_tick ? MODE_TICK : MODE_CLOSE, HDR_W'($urandom), LEN_W'($urandom),
			EP_W'($urandom), TMO_W'($urandom));
	endtask

	initial begin
		int steps [5];
		int fill_at;
		steps[0] = 1;
		steps[1] = 65535;
		steps[2] = 0;
		steps[3] = $urandom_range(2, 65534);
		steps[4] = 100;

		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_idles = 1'b1;

		issue(MODE_ALLOC, 8'hFF, 12'hFFF, 8'hFF, 16'hFFFF);
		issue(MODE_SEND, 8'h00, 12'h000, 8'h5A, 16'd10);
		issue(MODE_SEND, 8'h83, 12'hFFF, 8'hFF, 16'h0000);
		issue(MODE_SEND, 8'h00, 12'h001, 8'h00, 16'hFFFF);
		issue(MODE_SEND, 8'h7C, 12'h002, 8'hA5, 16'd100);
		issue(MODE_RESP, 8'h7C, 12'h000, 8'h00, 16'h0000);
		issue(MODE_RESP, 8'hFF, 12'h001, 8'hFF, 16'hFFFF);
		issue(MODE_RESP, 8'h14, 12'h002, 8'h00, 16'h0000);
		issue(MODE_FAIL, 8'h0C, 12'h000, 8'h00, 16'h0000);
		issue(MODE_SEND, 8'h0C, 12'h007, 8'h3C, 16'd250);
		issue(MODE_FAIL, 8'h8F, 12'h000, 8'hC3, 16'hFFFF);
		issue(MODE_RSVD_LO, 8'h0C, 12'hFFF, 8'hFF, 16'hFFFF);
		issue(MODE_RSVD_HI, 8'h00, 12'h000, 8'h00, 16'h0000);
		// deadline equal to the clock is not yet overdue
		issue(MODE_TICK, 8'h00, 12'h000, 8'h00, 16'h0000);
		issue(MODE_TICK, 8'hFF, 12'hFFF, 8'hFF, 16'hFFFF);
		issue(MODE_SEND, 8'h7F, 12'hFFF, 8'h11, 16'h0000);
		issue(MODE_SEND, 8'h40, 12'h003, 8'h22, 16'h0000);
		issue(MODE_TICK, 8'h00, 12'h000, 8'h00, 16'h0000);
		issue(MODE_RESP, 8'h00, 12'hFFF, 8'h00, 16'h0000);
		issue(MODE_SEND, 8'h24, 12'h010, 8'h99, 16'd5000);
		issue(MODE_SEND, 8'h50, 12'h800, 8'h66, 16'd5000);
		issue(MODE_CLOSE, 8'h00, 12'h000, 8'h00, 16'h0000);
		issue(MODE_CLOSE, 8'hFF, 12'hFFF, 8'hFF, 16'hFFFF);

		for (int p = 0; p < 5; p++) begin
			drain();
			write_tick_step(STEP_W'(steps[p]));
			sender_idles = (p != 4);
			fill_at = $urandom_range(0, RANDOM_PER_PHASE - 1);
			for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
				if (k == fill_at)
					fill_table(steps[p], steps[p] != 0 && p % 2 == 0);
				random_request(steps[p]);
			end
		end
		drain();

		if (tracker.mismatches == 0 && tracker.due_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// File: request_tracker_with_timeouts_core.f
hw/rtl/rtt_pkg.sv
hw/rtl/rtt_ctrl.sv
hw/rtl/rtt_dp.sv
hw/rtl/request_tracker_with_timeouts_core.sv
tb/tb_request_tracker_with_timeouts_core.sv
